/* hdl/single_wire_sensor_reader_assert.svh */
// Assertion macros for the file that checks its own logic (the reader top).
`ifndef SINGLE_WIRE_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_READER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/swsr_pkg.sv */
package swsr_pkg;

  // Bits taken by one byte read; bit i lands at position 7 - i.
  localparam int BITS_PER_READ = 8;
  localparam int BIT_IDX_W     = 3;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_PING = 2'd1;
  localparam op_t OP_READ = 2'd2;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_LOW      = 3'd0;
  localparam cfg_idx_t REG_START_HIGH     = 3'd1;
  localparam cfg_idx_t REG_RESPONSE_WAIT  = 3'd2;
  localparam cfg_idx_t REG_RESPONSE_CHECK = 3'd3;
  localparam cfg_idx_t REG_BIT_SAMPLE     = 3'd4;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] START_LOW_RST      = 16'd18000;
  localparam logic [7:0]  START_HIGH_RST     = 8'd30;
  localparam logic [7:0]  RESPONSE_WAIT_RST  = 8'd40;
  localparam logic [7:0]  RESPONSE_CHECK_RST = 8'd80;
  localparam logic [7:0]  BIT_SAMPLE_RST     = 8'd40;

  typedef struct packed {
    logic [15:0] start_low_us;
    logic [7:0]  start_high_us;
    logic [7:0]  response_wait_us;
    logic [7:0]  response_check_us;
    logic [7:0]  bit_sample_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic       response_ok;
    logic [7:0] data_byte;
  } res_t;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_START_LOW   = 9'b000000010,
    PH_START_HIGH  = 9'b000000100,
    PH_RESP_WAIT   = 9'b000001000,
    PH_RESP_CHECK  = 9'b000010000,
    PH_PING_END    = 9'b000100000,
    PH_BIT_HIGH    = 9'b001000000,
    PH_BIT_DELAY   = 9'b010000000,
    PH_BIT_LOW     = 9'b100000000
  } phase_e;

endpackage

/* hdl/swsr_if.sv */
// Command word: one microsecond tick with its command and line sample.
interface swsr_in_if;
  import swsr_pkg::*;
  logic valid;
  logic ready;
  op_t  op;
  logic line_level;

  modport source (output valid, output op, output line_level, input ready);
  modport sink   (input valid, input op, input line_level, output ready);
endinterface

// Result word: line drive and status after the tick.
interface swsr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       busy_res;
  logic       done_res;
  logic       response_ok;
  logic [7:0] data_byte;

  modport source (output valid, output drive_enable, output drive_level,
                  output busy_res, output done_res, output response_ok,
                  output data_byte, input ready);
  modport sink   (input valid, input drive_enable, input drive_level,
                  input busy_res, input done_res, input response_ok,
                  input data_byte, output ready);
endinterface

/* hdl/swsr_seq.sv */
module swsr_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  swsr_pkg::op_t  op_i,
  input  logic           line_level_i,
  input  swsr_pkg::cfg_t cfg_i,
  output swsr_pkg::res_t res_o
);
  import swsr_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [15:0]            tick_q, tick_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic                   answered_q, answered_d;
  logic                   driven_q, driven_d;
  logic                   expired;
  logic                   last_bit;
  logic                   done;

  // A timed wait ends once the count is down to one (or zero).
  assign expired  = (tick_q <= 16'd1);
  assign last_bit = (({1'b0, bit_q} + 4'd1) >= 4'(BITS_PER_READ));

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    answered_d = answered_q;
    driven_d   = driven_q;
    done       = 1'b0;
    if ((phase_q != PH_IDLE) && !expired) begin
      tick_d = tick_q - 16'd1;
    end
    unique case (phase_q)
      PH_IDLE: begin
        tick_d = tick_q;
        if (op_i == OP_PING) begin
          phase_d    = PH_START_LOW;
          tick_d     = cfg_i.start_low_us;
          driven_d   = 1'b1;
          answered_d = 1'b0;
        end else if (op_i == OP_READ) begin
          phase_d = PH_BIT_HIGH;
          bit_d   = '0;
          shift_d = '0;
        end
      end
      PH_START_LOW: begin
        if (expired) begin
          phase_d = PH_START_HIGH;
          tick_d  = 16'(cfg_i.start_high_us);
        end
      end
      PH_START_HIGH: begin
        if (expired) begin
          phase_d  = PH_RESP_WAIT;
          tick_d   = 16'(cfg_i.response_wait_us);
          driven_d = 1'b0;
        end
      end
      PH_RESP_WAIT: begin
        if (expired) begin
          if (!line_level_i) begin
            phase_d = PH_RESP_CHECK;
            tick_d  = 16'(cfg_i.response_check_us);
          end else begin
            phase_d = PH_PING_END;
          end
        end
      end
      PH_RESP_CHECK: begin
        if (expired) begin
          if (line_level_i) begin
            answered_d = 1'b1;
            phase_d    = PH_PING_END;
          end else begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      PH_PING_END: begin
        if (!line_level_i) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_BIT_HIGH: begin
        tick_d = tick_q;
        if (line_level_i) begin
          phase_d = PH_BIT_DELAY;
          tick_d  = 16'(cfg_i.bit_sample_us);
        end
      end
      PH_BIT_DELAY: begin
        if (expired) begin
          if (line_level_i) begin
            // 7 - i on three bits is the complement of i
            shift_d[~bit_q] = 1'b1;
            phase_d         = PH_BIT_LOW;
          end else if (last_bit) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            bit_d   = bit_q + 1'b1;
            phase_d = PH_BIT_HIGH;
          end
        end
      end
      PH_BIT_LOW: begin
        tick_d = tick_q;
        if (!line_level_i) begin
          if (last_bit) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            bit_d   = bit_q + 1'b1;
            phase_d = PH_BIT_HIGH;
          end
        end
      end
      default: begin
        tick_d   = tick_q;
        phase_d  = PH_IDLE;
        driven_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.drive_enable = driven_d;
    res_o.drive_level  = driven_d && (phase_d == PH_START_HIGH);
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.response_ok  = answered_d;
    res_o.data_byte    = shift_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      answered_q <= 1'b0;
      driven_q   <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      answered_q <= answered_d;
      driven_q   <= driven_d;
    end
  end

endmodule

/* hdl/single_wire_sensor_reader.sv */
// Host side of a single-wire temperature/humidity sensor link. Feed one command
// word per microsecond tick: op (plain tick, ping, byte read) plus the sampled
// data line level. Each accepted word yields exactly one result word that
// shows the line drive (drive_enable, drive_level), busy_res, done_res on the
// tick a command finishes, the latest ping outcome (response_ok) and the byte
// being assembled (data_byte, MSB first). Commands arriving while busy are
// ignored; waits on line edges have no timeout. Timing registers are written
// through the cfg port; the user must do so only while the block is idle,
// which the block itself does not enforce. A duration of zero acts as one tick.
// Throughput is one word per clock until a stalled output fills the output
// register and blocks the input. The sequencer state (phase, tick counter,
// bit index, shift byte) updates in a single pass per word; the result is
// written into the output register at the edge that takes the word and offered in the next cycle.
module single_wire_sensor_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  swsr_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  swsr_in_if.sink                             in_i,
  swsr_out_if.source                          out_o
);
  import swsr_pkg::*;

  `include "single_wire_sensor_reader_assert.svh"

  cfg_t cfg_q;
  res_t seq_res;
  res_t res_q;
  logic out_valid_q;
  logic in_fire;

  // Take a new word whenever the output register is empty or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Timing registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_us      <= START_LOW_RST;
      cfg_q.start_high_us     <= START_HIGH_RST;
      cfg_q.response_wait_us  <= RESPONSE_WAIT_RST;
      cfg_q.response_check_us <= RESPONSE_CHECK_RST;
      cfg_q.bit_sample_us     <= BIT_SAMPLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_LOW:      cfg_q.start_low_us      <= cfg_data_i;
        REG_START_HIGH:     cfg_q.start_high_us     <= cfg_data_i[7:0];
        REG_RESPONSE_WAIT:  cfg_q.response_wait_us  <= cfg_data_i[7:0];
        REG_RESPONSE_CHECK: cfg_q.response_check_us <= cfg_data_i[7:0];
        REG_BIT_SAMPLE:     cfg_q.bit_sample_us     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Phase sequencer: advances once per accepted word.
  swsr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .op_i         (in_i.op),
    .line_level_i (in_i.line_level),
    .cfg_i        (cfg_q),
    .res_o        (seq_res)
  );

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= seq_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_enable = res_q.drive_enable;
  assign out_o.drive_level  = res_q.drive_level;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.response_ok  = res_q.response_ok;
  assign out_o.data_byte    = res_q.data_byte;

  `SWSR_ASSERT_NEXT(a_fire_fills_out, in_fire, out_valid_q, "accepted word produced no result")
  `SWSR_ASSERT_NOW(a_stall_blocks_in, out_valid_q && !out_o.ready, !in_i.ready, "input taken over a stalled result")
  `SWSR_ASSERT_NOW(a_level_needs_drive, out_valid_q && res_q.drive_level, res_q.drive_enable, "line level shown while released")
  `SWSR_ASSERT_NOW(a_done_not_busy, out_valid_q && res_q.done_res, !res_q.busy_res, "command finished but still busy")

endmodule

/* tb/single_wire_sensor_reader_checker.sv */
`timescale 1ns / 100ps

module single_wire_sensor_reader_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  swsr_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  swsr_in_if                              cmd_i,
  swsr_out_if                             res_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import swsr_pkg::*;

  // Timing registers as the block should hold them.
  cfg_t        regs;

  // Link sequencer state.
  phase_e      ph;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  byte_sr;
  logic        answered;
  logic        driving;

  // Status words predicted for accepted command words, oldest first.
  res_t        status_q[$];
  int          fail_count = 0;

  assign fail_count_o = fail_count;

  // Count one tick of a timed wait; a loaded zero or one ends at once.
  function automatic logic timer_done();
    if (tick_cnt > 16'd1) begin
      tick_cnt = tick_cnt - 16'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Close one data bit; true once the whole byte is in.
  function automatic logic next_bit();
    if (int'(bit_idx) + 1 >= BITS_PER_READ) begin
      ph = PH_IDLE;
      return 1'b1;
    end
    bit_idx = bit_idx + 3'd1;
    ph = PH_BIT_HIGH;
    return 1'b0;
  endfunction

  // Advance the link by one tick and return the status word it shows.
  function automatic res_t step_link(op_t op, logic lvl);
    res_t r;
    logic fin;
    fin = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (op == OP_PING) begin
          ph       = PH_START_LOW;
          tick_cnt = regs.start_low_us;
          driving  = 1'b1;
          answered = 1'b0;
        end else if (op == OP_READ) begin
          ph      = PH_BIT_HIGH;
          bit_idx = 3'd0;
          byte_sr = 8'h00;
        end
      end
      PH_START_LOW: begin
        if (timer_done()) begin
          ph       = PH_START_HIGH;
          tick_cnt = {8'h00, regs.start_high_us};
        end
      end
      PH_START_HIGH: begin
        if (timer_done()) begin
          ph       = PH_RESP_WAIT;
          tick_cnt = {8'h00, regs.response_wait_us};
          driving  = 1'b0;
        end
      end
      PH_RESP_WAIT: begin
        if (timer_done()) begin
          if (!lvl) begin
            ph       = PH_RESP_CHECK;
            tick_cnt = {8'h00, regs.response_check_us};
          end else begin
            ph = PH_PING_END;
          end
        end
      end
      PH_RESP_CHECK: begin
        if (timer_done()) begin
          if (lvl) begin
            answered = 1'b1;
            ph       = PH_PING_END;
          end else begin
            ph  = PH_IDLE;
            fin = 1'b1;
          end
        end
      end
      PH_PING_END: begin
        if (!lvl) begin
          ph  = PH_IDLE;
          fin = 1'b1;
        end
      end
      PH_BIT_HIGH: begin
        if (lvl) begin
          ph       = PH_BIT_DELAY;
          tick_cnt = {8'h00, regs.bit_sample_us};
        end
      end
      PH_BIT_DELAY: begin
        if (timer_done()) begin
          if (lvl) begin
            byte_sr[3'd7 - bit_idx] = 1'b1;
            ph = PH_BIT_LOW;
          end else begin
            fin = next_bit();
          end
        end
      end
      PH_BIT_LOW: begin
        if (!lvl) fin = next_bit();
      end
      default: begin
        ph      = PH_IDLE;
        driving = 1'b0;
      end
    endcase
    r.drive_enable = driving;
    r.drive_level  = driving && (ph == PH_START_HIGH);
    r.busy_res     = (ph != PH_IDLE);
    r.done_res     = fin;
    r.response_ok  = answered;
    r.data_byte    = byte_sr;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      regs.start_low_us      = START_LOW_RST;
      regs.start_high_us     = START_HIGH_RST;
      regs.response_wait_us  = RESPONSE_WAIT_RST;
      regs.response_check_us = RESPONSE_CHECK_RST;
      regs.bit_sample_us     = BIT_SAMPLE_RST;
      ph       = PH_IDLE;
      tick_cnt = 16'd0;
      bit_idx  = 3'd0;
      byte_sr  = 8'h00;
      answered = 1'b0;
      driving  = 1'b0;
      status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_LOW:      regs.start_low_us      = cfg_data_i[15:0];
          REG_START_HIGH:     regs.start_high_us     = cfg_data_i[7:0];
          REG_RESPONSE_WAIT:  regs.response_wait_us  = cfg_data_i[7:0];
          REG_RESPONSE_CHECK: regs.response_check_us = cfg_data_i[7:0];
          REG_BIT_SAMPLE:     regs.bit_sample_us     = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: status word expected none, got busy %0b done %0b byte %0h",
                   $time, res_i.busy_res, res_i.done_res, res_i.data_byte);
        end else begin
          want = status_q.pop_front();
          check_field("drive_enable", 8'(want.drive_enable), 8'(res_i.drive_enable));
          check_field("drive_level", 8'(want.drive_level), 8'(res_i.drive_level));
          check_field("busy_res", 8'(want.busy_res), 8'(res_i.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_i.done_res));
          check_field("response_ok", 8'(want.response_ok), 8'(res_i.response_ok));
          check_field("data_byte", want.data_byte, res_i.data_byte);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        status_q.push_back(step_link(cmd_i.op, cmd_i.line_level));
      pending_o <= status_q.size();
    end
  end

endmodule

/* tb/single_wire_sensor_reader_tb.sv */
`timescale 1ns / 100ps

module single_wire_sensor_reader_tb;
  import swsr_pkg::*;

  // Spare op code; the block takes it as a plain tick.
  localparam op_t      OP_SPARE   = 2'd3;
  // Index past the last timing register; writes there go nowhere.
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  typedef enum int {PING_GOOD, PING_NO_LOW, PING_NO_HIGH} ping_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  swsr_in_if  cmd_if ();
  swsr_out_if res_if ();

  int fail_count;
  int pending;

  // Busy flag of the last status word taken; tells the sensor side when
  // the link has settled back to idle.
  logic link_busy = 1'b0;

  // Sender state: remaining words in the current burst, gap enable, and
  // a running count of words offered and taken.
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b0;
  int unsigned ticks_sent = 0;

  // Timing registers as last written, used to shape the sensor waveform.
  int c_lo  = int'(START_LOW_RST);
  int c_hi  = int'(START_HIGH_RST);
  int c_wt  = int'(RESPONSE_WAIT_RST);
  int c_chk = int'(RESPONSE_CHECK_RST);
  int c_smp = int'(BIT_SAMPLE_RST);

  single_wire_sensor_reader DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  single_wire_sensor_reader_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Track the busy bit of every status word the sink takes.
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) link_busy <= res_if.busy_res;
  end

  // Result sink: switch between random stall modes, and, while the sender is
  // offering, now and then hold off for a long stretch so the output fills
  // and the input stalls.
  initial begin : result_sink
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned next_hold;
    int unsigned mode;
    cyc       = 0;
    hold_left = 0;
    next_hold = 150;
    mode      = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 200 == 0) mode = $urandom_range(0, 3);
      if ((hold_left == 0) && (cyc >= next_hold) && cmd_if.valid) begin
        hold_left = 40;
        next_hold = cyc + 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 3) != 0);
          2:       res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  // A zero duration acts as one tick.
  function automatic int span(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Op for ticks inside a command: mostly plain, sometimes a stray command
  // that the busy block has to drop.
  function automatic op_t busy_op();
    case ($urandom_range(0, 11))
      0:       return OP_PING;
      1:       return OP_READ;
      2:       return OP_SPARE;
      default: return OP_TICK;
    endcase
  endfunction

  // Offer one command word and hold it until taken. Open each burst with
  // a random gap when gaps are enabled.
  task automatic send_tick(input op_t op, input logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.op         <= op;
    cmd_if.line_level <= lvl;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    burst_left--;
    ticks_sent++;
  endtask

  // Drop valid and hold until every predicted status word has come back.
  task automatic wait_quiet();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Toggle the line with plain ticks until the link reports idle; any
  // wait the block can be in ends on one of the two levels.
  task automatic drain_link();
    logic lvl;
    lvl = 1'b1;
    wait_quiet();
    while (link_busy) begin
      send_tick(OP_TICK, lvl);
      lvl = ~lvl;
      wait_quiet();
    end
  endtask

  // Write every timing register, plus a stray write to an unused index.
  // Junk goes in the upper byte of the 8-bit registers.
  task automatic apply_config(input int lo, input int hi, input int wt,
                              input int chk, input int smp);
    drain_link();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_START_LOW;
    cfg_data_i <= CFG_DATA_W'(lo);
    @(posedge clk_i);
    cfg_idx_i  <= REG_START_HIGH;
    cfg_data_i <= {8'($urandom), 8'(hi)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_RESPONSE_WAIT;
    cfg_data_i <= {8'($urandom), 8'(wt)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_RESPONSE_CHECK;
    cfg_data_i <= {8'($urandom), 8'(chk)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_BIT_SAMPLE;
    cfg_data_i <= {8'($urandom), 8'(smp)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    c_lo  = lo;
    c_hi  = hi;
    c_wt  = wt;
    c_chk = chk;
    c_smp = smp;
  endtask

  // Ping with a sensor answer timed to the register values. The line is
  // don't-care while the block drives it; then low at the response check,
  // high at the second check, and low again to finish. The broken kinds
  // fail one of the two checks.
  task automatic ping_seq(input ping_kind_e kind);
    int drive_ticks;
    int m;
    drive_ticks = span(c_lo) + span(c_hi) + span(c_wt);
    send_tick(OP_PING, 1'($urandom));
    for (int t = 1; t < drive_ticks; t++) send_tick(busy_op(), 1'($urandom));
    send_tick(busy_op(), kind == PING_NO_LOW);
    if (kind != PING_NO_LOW) begin
      m = $urandom_range(0, span(c_chk) - 1);
      for (int t = 1; t < span(c_chk); t++) send_tick(busy_op(), t > m);
      send_tick(busy_op(), kind != PING_NO_HIGH);
    end
    if (kind != PING_NO_HIGH) begin
      repeat ($urandom_range(0, 3)) send_tick(busy_op(), 1'b1);
      send_tick(busy_op(), 1'b0);
    end
  endtask

  // Byte read, MSB first. Each bit: a few low ticks, a rising tick, then a
  // one stays high past the sample point and drops; a zero drops before
  // or on the sample tick.
  task automatic read_seq(input logic [7:0] value);
    int j;
    send_tick(OP_READ, 1'($urandom));
    for (int i = 7; i > 7 - BITS_PER_READ; i--) begin
      repeat ($urandom_range(0, 3)) send_tick(busy_op(), 1'b0);
      send_tick(busy_op(), 1'b1);
      if (value[i]) begin
        repeat (span(c_smp) + $urandom_range(0, 3)) send_tick(busy_op(), 1'b1);
        send_tick(busy_op(), 1'b0);
      end else begin
        j = $urandom_range(0, span(c_smp) - 1);
        repeat (j) send_tick(busy_op(), 1'b1);
        repeat (span(c_smp) - j) send_tick(busy_op(), 1'b0);
      end
    end
  endtask

  // Random ops and levels with no structure, then settle the link.
  task automatic noise_seq();
    repeat ($urandom_range(10, 40)) send_tick(op_t'($urandom_range(0, 3)), 1'($urandom));
    drain_link();
  endtask

  initial begin : stimulus
    int unsigned mark;
    int unsigned pick;
    cmd_if.valid      <= 1'b0;
    cmd_if.op         <= OP_TICK;
    cmd_if.line_level <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_START_LOW;
    cfg_data_i        <= '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All zero: every timed wait collapses to one tick.
    gaps_on = 1'b1;
    apply_config(0, 0, 0, 0, 0);
    send_tick(OP_SPARE, 1'b1);
    send_tick(OP_SPARE, 1'b0);
    send_tick(OP_TICK, 1'b1);
    ping_seq(PING_GOOD);
    ping_seq(PING_NO_LOW);
    ping_seq(PING_NO_HIGH);
    read_seq(8'h00);
    read_seq(8'hFF);
    read_seq(8'h5A);

    // Random phases: short waits, mostly well-formed traffic with random
    // content, some broken pings and raw noise.
    for (int p = 0; p < 4; p++) begin
      apply_config($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 6), $urandom_range(0, 6));
      gaps_on = ($urandom_range(0, 3) != 0);
      mark = ticks_sent;
      while (ticks_sent - mark < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      read_seq(8'($urandom));
        else if (pick < 65) ping_seq(PING_GOOD);
        else if (pick < 75) ping_seq(PING_NO_LOW);
        else if (pick < 85) ping_seq(PING_NO_HIGH);
        else                noise_seq();
        if ($urandom_range(0, 9) == 0) wait_quiet();
      end
    end

    // Let the last status words drain, then allow the output register to
    // flush anything stray.
    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("single_wire_sensor_reader_tb passed");
    end else begin
      $display("single_wire_sensor_reader_tb failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("single_wire_sensor_reader_tb failed");
    $finish;
  end

endmodule
